>>> rtl/lphm_pkg.sv
// ============================================================================
// Linear probe hash map package
// Shared widths, codes, state encoding and controller/datapath bundles.
// ============================================================================
package lphm_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 4;
    localparam int STAT_W = 2;

    // Multiplicative hash constant; the home slot is the low bits of key * HASH_MULT.
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

    // Operation codes carried in the func field.
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT  = 2'd0,
        ST_MISS = 2'd1,
        ST_NEW  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic load_hash;
        logic advance;
        logic clear_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic hit;
        logic free;
        logic last_probe;
        logic clear_done;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/lphm_if.sv
// ============================================================================
// Linear probe hash map channels
// Request and response valid/ready channels with their payload.
// ============================================================================
interface lphm_req_if;
    import lphm_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] store_value;

    modport source (output valid, func, lookup_key, store_value, input ready);
    modport sink   (input valid, func, lookup_key, store_value, output ready);
endinterface

interface lphm_rsp_if;
    import lphm_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

>>> rtl/lphm_ram.sv
// ============================================================================
// Linear probe hash map RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lphm_ctrl.sv
// ============================================================================
// Linear probe hash map controller
// Sequences the clearing pass, the hash step and the probe loop.
// ============================================================================
module lphm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lphm_pkg::t_dp_stat i_stat,
    output lphm_pkg::t_dp_cmd  o_cmd
);
    import lphm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.load_hash = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // The probe ends on a match, a free slot or the last slot in use.
                if (i_stat.hit || i_stat.free || i_stat.last_probe) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/lphm_dp.sv
// ============================================================================
// Linear probe hash map datapath
// Item registers, hash, probe index, slot memories and the result register.
// ============================================================================
module lphm_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lphm_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                        i_func,
    input  logic [lphm_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic [lphm_pkg::VAL_W-1:0]  i_store_value,
    input  lphm_pkg::t_dp_cmd           i_cmd,
    output lphm_pkg::t_dp_stat          o_stat,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lphm_pkg::VAL_W-1:0]  o_read_value,
    output logic [lphm_pkg::STAT_W-1:0] o_status
);
    import lphm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] MULT_LO = HASH_MULT[AW-1:0];
    localparam logic [4:0] AW_MAX = 5'(AW);

    logic [SIZE_W-1:0] r_size_log2;
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_count;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_read_value;
    logic [STAT_W-1:0] r_status;

    logic [4:0]               size_eff;
    logic [AW-1:0]            mask;
    logic [AW-1:0]            prod;
    logic                     used_q;
    logic [KEY_W+VAL_W-1:0]   entry_q;
    logic                     is_put;
    logic                     hit;
    logic                     free;
    logic                     used_we;
    logic [AW-1:0]            used_waddr;
    logic                     entry_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_wdata;
        end
    end

    // A size of zero acts as one; sizes past the table depth are clamped.
    always_comb begin
        size_eff = {1'b0, r_size_log2};
        if (size_eff == 5'd0) begin
            size_eff = 5'd1;
        end
        if (size_eff > AW_MAX) begin
            size_eff = AW_MAX;
        end
        for (int j = 0; j < AW; j++) begin
            mask[j] = (5'(j) < size_eff);
        end
    end

    assign prod = r_key[AW-1:0] * MULT_LO;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_key  <= i_lookup_key;
            r_val  <= i_store_value;
        end
        if (i_cmd.load_hash) begin
            r_idx   <= prod & mask;
            r_count <= '0;
        end else if (i_cmd.advance) begin
            r_idx   <= (r_idx + 1'b1) & mask;
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign is_put     = (r_func == FUNC_PUT);
    assign free       = !used_q;
    assign hit        = used_q && (entry_q[KEY_W+VAL_W-1:VAL_W] == r_key);
    assign used_we    = i_cmd.clear_step || (i_cmd.commit && is_put && free);
    assign used_waddr = i_cmd.clear_step ? r_clr_addr : r_idx;
    assign entry_we   = i_cmd.commit && is_put && (hit || free);

    lphm_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (!i_cmd.clear_step),
        .i_raddr (r_idx),
        .o_rdata (used_q)
    );

    lphm_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (r_idx),
        .i_wdata ({r_key, r_val}),
        .i_raddr (r_idx),
        .o_rdata (entry_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_read_value <= '0;
            if (hit) begin
                r_status <= ST_HIT;
                if (!is_put) begin
                    r_read_value <= entry_q[VAL_W-1:0];
                end
            end else if (free) begin
                r_status <= is_put ? ST_NEW : ST_MISS;
            end else begin
                r_status <= is_put ? ST_FULL : ST_MISS;
            end
        end
    end

    assign o_stat.hit        = hit;
    assign o_stat.free       = free;
    assign o_stat.last_probe = (r_count == mask);
    assign o_stat.clear_done = (r_clr_addr == '1);
    assign o_stat.out_busy   = r_out_valid && !i_ready;

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule

>>> rtl/linear_probe_hash_map_top.sv
// ============================================================================
// Linear probe hash map
// 32-bit key to 32-bit value map with open addressing and linear probing.
// ============================================================================
// After reset the block sweeps its slot-used memory, one slot per cycle, over
// every slot; request ready stays low until that pass is done, while
// the size register can already be written. Each request word is a get or a
// put; its home slot is the key times 2654435761, masked to 2^size_log2 slots
// (a size of zero acts as one, larger sizes are clamped to the table depth).
// A request passes through an accept state, a hash multiply state and then
// a read and a compare state per probe, for P probed slots (one to the table
// size in use), because each probe is a registered read of the slot memories
// followed by a compare; no new request is taken until that one commits.
// The finished response word sits in an output register, so the next
// request is accepted while it waits; a probe that ends while the previous
// response is still unread holds until it drains.
// A put with no match and no free slot reports table full and changes nothing.
// Writing the size register does not touch stored entries and is only done
// while no request is in flight: the user must ensure it, the block does not.
// ============================================================================
module linear_probe_hash_map_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lphm_pkg::SIZE_W-1:0] i_cfg_wdata,
    lphm_req_if.sink                    i_req,
    lphm_rsp_if.source                  o_rsp
);
    import lphm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller owns sequencing; it only sees the request valid.
    lphm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the size register, the slot memories and the
    // response register.
    lphm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_req.func),
        .i_lookup_key  (i_req.lookup_key),
        .i_store_value (i_req.store_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_read_value  (o_rsp.read_value),
        .o_status      (o_rsp.status)
    );

    // A request word is never followed by another accept in the next cycle.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted twice in a row");

    // No request is taken while the clearing pass runs.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_step |-> !i_req.ready)
        else $error("request ready during clearing pass");

    // Every committed probe shows up as a response word.
    a_commit_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_rsp.valid)
        else $error("committed result not presented");

    // Only a get that hits can return a nonzero value.
    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_HIT)) |-> (o_rsp.read_value == '0))
        else $error("nonzero value without a hit");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Linear probe hash map testbench
// Drives get and put words into the hash map under a series of table sizes.
// Every response word is checked against a scoreboard model of the table,
// with random stalls on both the request and the response side.
// ============================================================================
module testbench;
    import lphm_pkg::*;

    localparam int          MAP_DEPTH      = 1024;
    localparam logic [31:0] GOLDEN_MULT    = 32'd2654435761;
    // The limit leaves room for the clearing sweep after reset and for a put
    // that probes a full table of MAP_DEPTH slots, on top of the longest
    // receiver stall.
    localparam int          WATCHDOG_LIMIT = 10000;
    localparam int          REPORT_LIMIT   = 10;

    // One request word and one response word as the scoreboard sees them.
    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [31:0] value;
    } t_req_word;

    typedef struct packed {
        logic [31:0] read_value;
        t_status     status;
    } t_rsp_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    lphm_req_if req_ch ();
    lphm_rsp_if rsp_ch ();

    linear_probe_hash_map_top #(
        .TABLE_DEPTH(MAP_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard copy of the hash map. The key and value stores are only read
    // where the used flag is set, so their initial content never matters.
    // ------------------------------------------------------------------------
    bit          map_used  [MAP_DEPTH];
    logic [31:0] map_key   [MAP_DEPTH];
    logic [31:0] map_value [MAP_DEPTH];
    logic [3:0]  map_size_log2 = SIZE_RESET;

    t_req_word   pending_q [$];   // words waiting to be driven
    t_rsp_word   expect_q  [$];   // predicted responses, oldest first
    logic [31:0] key_pool  [$];   // keys that were put, reused for hits

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned fail_count = 0;
    int unsigned words_checked = 0;
    int unsigned size_settings = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned stall_cycles = 0;

    // Runs one get or put against the scoreboard table and returns the
    // response word the block should give for it.
    function automatic t_rsp_word probe_map(input t_req_word w);
        t_rsp_word   r;
        int unsigned s;
        int unsigned slots;
        int unsigned mask;
        int unsigned idx;
        int unsigned probe;
        logic [31:0] home;
        bit          done;

        // A size of zero acts as one; sizes beyond the table are clamped.
        s = map_size_log2;
        if (s < 1) begin
            s = 1;
        end
        while (s > 1 && (1 << s) > MAP_DEPTH) begin
            s--;
        end
        slots = 1 << s;
        mask  = slots - 1;
        home  = w.key * GOLDEN_MULT;
        idx   = home & mask;

        r.read_value = '0;
        if (w.func == FUNC_PUT) begin
            r.status = ST_FULL;
        end else begin
            r.status = ST_MISS;
        end
        done = 1'b0;
        for (probe = 0; probe < slots && !done; probe++) begin
            if (!map_used[idx]) begin
                if (w.func == FUNC_PUT) begin
                    map_used[idx]  = 1'b1;
                    map_key[idx]   = w.key;
                    map_value[idx] = w.value;
                    r.status       = ST_NEW;
                end else begin
                    r.status = ST_MISS;
                end
                done = 1'b1;
            end else if (map_key[idx] == w.key) begin
                if (w.func == FUNC_PUT) begin
                    map_value[idx] = w.value;
                end else begin
                    r.read_value = map_value[idx];
                end
                r.status = ST_HIT;
                done = 1'b1;
            end else begin
                idx = (idx + 1) & mask;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A word stays on the channel until it is taken; a new
    // word is only put up when the sender is not idling this cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        t_req_word w;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                w = pending_q.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.func        <= w.func;
                req_ch.lookup_key  <= w.key;
                req_ch.store_value <= w.value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response side: ready is redrawn every cycle to produce random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Responses are checked before the request taken at the same
    // edge is predicted; the block never answers a word in its own cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_req_word w;
        t_rsp_word want;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                words_checked++;
                status_seen[rsp_ch.status]++;
                if (expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: response word with none expected: value %h status %0d",
                                 $realtime, rsp_ch.read_value, rsp_ch.status);
                    end
                end else begin
                    want = expect_q.pop_front();
                    if (rsp_ch.read_value !== want.read_value ||
                        rsp_ch.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                                     $realtime, want.read_value, want.status,
                                     rsp_ch.read_value, rsp_ch.status);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                w.func  = req_ch.func;
                w.key   = req_ch.lookup_key;
                w.value = req_ch.store_value;
                expect_q.push_back(probe_map(w));
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too
    // long, which covers a hung block as well as a lost response.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_word(input logic func, input logic [31:0] key,
                            input logic [31:0] value);
        t_req_word w;
        w.func  = func;
        w.key   = key;
        w.value = value;
        pending_q.push_back(w);
    endtask

    // Returns once every queued word has been taken and answered.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_q.size() != 0 || req_ch.valid || expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The size register is only written with nothing in flight. The
    // scoreboard takes the new size at the edge that writes it.
    task automatic set_size(input logic [3:0] size_log2);
        wait_idle();
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size_log2;
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        map_size_log2 = size_log2;
        size_settings++;
        @(negedge i_clk);
    endtask

    // Mostly gets and puts on keys already stored, so that hits, updates and
    // probe chains are common, mixed with fresh random keys that miss or
    // claim new slots.
    task automatic add_random_words(input int count);
        logic        func;
        logic [31:0] key;
        bit          fresh;
        for (int k = 0; k < count; k++) begin
            func  = ($urandom_range(99) < 45) ? FUNC_PUT : FUNC_GET;
            fresh = (key_pool.size() == 0 || $urandom_range(99) < 30);
            if (fresh) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            if (fresh && func == FUNC_PUT) begin
                key_pool.push_back(key);
            end
            add_word(func, key, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        logic [3:0] sizes  [13];
        int         counts [13];

        sizes  = '{4'd3, 4'd1, 4'd5, 4'd10, 4'd2, 4'd12, 4'd4, 4'd6, 4'd0, 4'd7,
                   4'd15, 4'd3, 4'd9};
        counts = '{60, 40, 100, 200, 40, 150, 80, 120, 30, 150, 100, 60, 70};

        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_GET;
        req_ch.lookup_key  = '0;
        req_ch.store_value = '0;
        rsp_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first on a two-slot table reached through a size of
        // zero: a get on the empty table, inserts at both extremes of key and
        // value, a put that finds the table full, a get that probes the full
        // table and misses, hits and an update.
        src_idle_pct = 17;
        snk_idle_pct = 78;
        set_size(4'd0);
        add_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        add_word(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
        add_word(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(FUNC_PUT, 32'h1234_5678, 32'hAAAA_AAAA);
        add_word(FUNC_GET, 32'h1234_5678, 32'h5555_5555);
        add_word(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        add_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(FUNC_PUT, 32'h0000_0000, 32'h5555_5555);
        add_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);

        // The same two slots written as size one.
        set_size(4'd1);
        add_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // An oversized setting is clamped to the full table; the old entries
        // are only found where the wider mask still lands on them.
        set_size(4'd15);
        add_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        add_word(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        add_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        add_word(FUNC_PUT, 32'h0000_0001, 32'h0000_0001);
        add_word(FUNC_GET, 32'h0000_0001, 32'h0000_0000);

        set_size(4'd10);
        add_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        add_word(FUNC_PUT, 32'h8000_0000, 32'h8000_0000);
        add_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);

        // Random part: the table is kept across size changes, so small sizes
        // fill up and report full while larger ones reach entries left behind.
        for (int p = 0; p < 13; p++) begin
            if (p == 5) begin
                src_idle_pct = 78;
                snk_idle_pct = 17;
            end else if (p == 9) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            set_size(sizes[p]);
            add_random_words(counts[p]);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        if (expect_q.size() != 0) begin
            fail_count++;
            $display("%0d response words never arrived", expect_q.size());
        end
        $display("Checked %0d response words over %0d size settings, sender and receiver stalls.",
                 words_checked, size_settings);
        $display("Statuses seen: %0d hit, %0d not found, %0d inserted, %0d full; %0d failures.",
                 status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_NEW],
                 status_seen[ST_FULL], fail_count);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
